[design/pba_pkg.sv]
// ----------------------------------------------------------------------------
// pba_pkg
// Shared sizes, operation codes, item types and the controller/datapath
// command and status groups of the page bitmap allocator.
// ----------------------------------------------------------------------------
package pba_pkg;

    // map geometry
    localparam int NUM_PAGES  = 4096;
    localparam int PAGE_BYTES = 4096;
    localparam int MAP_WORDS  = (NUM_PAGES + 31) / 32;
    localparam int WORD_W     = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BIT_W      = 5;
    localparam int IDX_W      = WORD_W + BIT_W;
    localparam int PB_SH      = $clog2(PAGE_BYTES);
    localparam int LPW        = 64 - PB_SH;

    // field widths
    localparam int OP_W   = 3;
    localparam int ADDR_W = 24;
    localparam int CNT_W  = 13;
    localparam int CTR_W  = 32;

    localparam logic [63:0] PAGE_MASK = 64'(PAGE_BYTES - 1);
    localparam logic [63:0] MAP_BYTES = 64'(NUM_PAGES) * 64'(PAGE_BYTES);

    // operation codes
    localparam logic [OP_W-1:0] OP_ALLOC   = 3'd0;
    localparam logic [OP_W-1:0] OP_FREE    = 3'd1;
    localparam logic [OP_W-1:0] OP_RELEASE = 3'd2;
    localparam logic [OP_W-1:0] OP_RESERVE = 3'd3;
    localparam logic [OP_W-1:0] OP_START   = 3'd4;
    localparam logic [OP_W-1:0] OP_RESTART = 3'd5;

    typedef struct packed {
        logic [OP_W-1:0] operation;
        logic [63:0]     address;
        logic [63:0]     length;
    } t_in_item;

    typedef struct packed {
        logic [ADDR_W-1:0] page_address;
        logic              success;
        logic [CNT_W-1:0]  total_pages;
        logic [CNT_W-1:0]  used_pages;
        logic [CNT_W-1:0]  free_pages;
        logic [CTR_W-1:0]  alloc_count;
        logic [CTR_W-1:0]  free_count;
        logic [CTR_W-1:0]  failed_count;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic set_ready;
        logic restart;
        logic count_fail;
        logic scan_init;
        logic ptr_inc;
        logic alloc_commit;
        logic free_load;
        logic free_commit;
        logic range_sum;
        logic range_chk;
        logic walk_init;
        logic walk_commit;
        logic load_out;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            ready;
        logic            free_ok;
        logic            word_has_free;
        logic            idx_in_map;
        logic            scan_end;
        logic            bit_set;
        logic            range_ok;
        logic            walk_end;
        logic            out_free;
    } t_sts;

endpackage

[design/pba_ctrl.sv]
// ----------------------------------------------------------------------------
// pba_ctrl
// Sequencer for the allocator: decodes each item and steps the datapath
// through word scans, single page updates and range walks.
// ----------------------------------------------------------------------------
module pba_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  pba_pkg::t_sts i_sts,
    output pba_pkg::t_cmd o_cmd,
    output logic          o_in_stall
);
    import pba_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_FREE_RD,
        S_FREE_WR,
        S_RNG_A,
        S_RNG_B,
        S_WALK_RD,
        S_WALK_WR,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_stall;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_sts.op)
                    OP_ALLOC: begin
                        if (i_sts.ready) begin
                            o_cmd.scan_init = 1'b1;
                            n_state         = S_SCAN_RD;
                        end else begin
                            o_cmd.count_fail = 1'b1;
                            n_state          = S_DONE;
                        end
                    end
                    OP_FREE: begin
                        if (i_sts.free_ok) begin
                            o_cmd.free_load = 1'b1;
                            n_state         = S_FREE_RD;
                        end else begin
                            n_state = S_DONE;
                        end
                    end
                    OP_RELEASE, OP_RESERVE: begin
                        o_cmd.range_sum = 1'b1;
                        n_state         = S_RNG_A;
                    end
                    OP_START: begin
                        o_cmd.set_ready = 1'b1;
                        n_state         = S_DONE;
                    end
                    OP_RESTART: begin
                        o_cmd.restart = 1'b1;
                        n_state       = S_DONE;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_SCAN_RD: begin
                n_state = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                if (i_sts.word_has_free) begin
                    if (i_sts.idx_in_map) begin
                        o_cmd.alloc_commit = 1'b1;
                    end else begin
                        o_cmd.count_fail = 1'b1;
                    end
                    n_state = S_DONE;
                end else if (i_sts.scan_end) begin
                    o_cmd.count_fail = 1'b1;
                    n_state          = S_DONE;
                end else begin
                    o_cmd.ptr_inc = 1'b1;
                    n_state       = S_SCAN_RD;
                end
            end
            S_FREE_RD: begin
                n_state = S_FREE_WR;
            end
            S_FREE_WR: begin
                o_cmd.free_commit = i_sts.bit_set;
                n_state           = S_DONE;
            end
            S_RNG_A: begin
                o_cmd.range_chk = 1'b1;
                n_state         = S_RNG_B;
            end
            S_RNG_B: begin
                if (i_sts.range_ok) begin
                    o_cmd.walk_init = 1'b1;
                    n_state         = S_WALK_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_WALK_RD: begin
                n_state = S_WALK_WR;
            end
            S_WALK_WR: begin
                o_cmd.walk_commit = 1'b1;
                if (i_sts.walk_end) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.ptr_inc = 1'b1;
                    n_state       = S_WALK_RD;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered stall
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_stall <= 1'b0;
        end else begin
            r_state <= n_state;
            r_stall <= (n_state != S_IDLE);
        end
    end

    assign o_in_stall = r_stall;

endmodule

[design/pba_datapath.sv]
// ----------------------------------------------------------------------------
// pba_datapath
// Used-page map memory with per-word valid bits, range arithmetic, counters
// and the output register of the page bitmap allocator.
// ----------------------------------------------------------------------------
module pba_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pba_pkg::t_in_item   i_in_item,
    input  pba_pkg::t_cmd       i_cmd,
    input  logic                i_out_stall,
    output pba_pkg::t_sts       o_sts,
    output logic                o_out_valid,
    output pba_pkg::t_out_item  o_out_item
);
    import pba_pkg::*;

    localparam logic [IDX_W:0]  NP_IDX  = (IDX_W + 1)'(NUM_PAGES);
    localparam logic [LPW-1:0]  NP_LPW  = LPW'(NUM_PAGES);
    localparam logic [WORD_W-1:0] LAST_WORD = WORD_W'(MAP_WORDS - 1);

    // map storage; a word with its valid bit low reads as all used
    logic [31:0]          r_map [MAP_WORDS];
    logic [31:0]          r_rdata;
    logic [MAP_WORDS-1:0] r_word_valid;
    logic                 r_rvalid;

    // item and work registers
    t_in_item             r_item;
    logic [WORD_W-1:0]    r_ptr;
    logic [BIT_W-1:0]     r_bit;
    logic [64:0]          r_sum_len;
    logic [64:0]          r_sum_pm;
    logic                 r_len_zero;
    logic                 r_range_ok;
    logic [IDX_W-1:0]     r_first;
    logic [IDX_W-1:0]     r_lastm1;
    logic                 r_ok;
    logic [ADDR_W-1:0]    r_page;

    // counters
    logic                 r_ready;
    logic [CNT_W-1:0]     r_total;
    logic [CNT_W-1:0]     r_used;
    logic [CTR_W-1:0]     r_alloc_cnt;
    logic [CTR_W-1:0]     r_free_cnt;
    logic [CTR_W-1:0]     r_fail_cnt;

    // output register
    logic                 r_out_valid;
    t_out_item            r_out;

    logic [31:0]          cur_word;
    logic [31:0]          inv_word;
    logic [BIT_W-1:0]     first_bit;
    logic [IDX_W-1:0]     free_idx;
    logic [63:0]          alloc_addr;
    logic [LPW-1:0]       lo_pg;
    logic [LPW-1:0]       hi_pg;
    logic [LPW-1:0]       hi_m1;
    logic [BIT_W-1:0]     lo_b;
    logic [BIT_W-1:0]     hi_b;
    logic [31:0]          walk_mask;
    logic [31:0]          changed;
    logic [31:0]          walk_word;
    logic [5:0]           pop;
    logic                 mem_we;
    logic [31:0]          mem_wdata;
    logic                 is_release;

    assign cur_word   = r_rvalid ? r_rdata : '1;
    assign inv_word   = ~cur_word;
    assign is_release = (r_item.operation == OP_RELEASE);

    // lowest free bit of the current word
    always_comb begin
        first_bit = '0;
        for (int k = 31; k >= 0; k--) begin
            if (inv_word[k]) begin
                first_bit = BIT_W'(k);
            end
        end
    end

    assign alloc_addr = 64'({r_ptr, first_bit}) << PB_SH;

    // page index of a free request
    assign free_idx = r_item.address[PB_SH +: IDX_W];

    // page bounds from the rounded sums
    assign lo_pg = r_sum_pm[63:PB_SH];
    assign hi_pg = r_sum_len[63:PB_SH];
    assign hi_m1 = hi_pg - LPW'(1);

    // bit span of the walk within the current word
    assign lo_b = (r_ptr == r_first[IDX_W-1:BIT_W])  ? r_first[BIT_W-1:0]  : '0;
    assign hi_b = (r_ptr == r_lastm1[IDX_W-1:BIT_W]) ? r_lastm1[BIT_W-1:0] : '1;
    assign walk_mask = (32'hFFFF_FFFF << lo_b) & (32'hFFFF_FFFF >> (5'd31 - hi_b));

    assign changed   = is_release ? (cur_word & walk_mask) : (~cur_word & walk_mask);
    assign walk_word = is_release ? (cur_word & ~walk_mask) : (cur_word | walk_mask);
    assign pop       = 6'($countones(changed));

    // map write data
    always_comb begin
        mem_we    = i_cmd.alloc_commit | i_cmd.free_commit | i_cmd.walk_commit;
        mem_wdata = walk_word;
        if (i_cmd.alloc_commit) begin
            mem_wdata = cur_word | (32'd1 << first_bit);
        end else if (i_cmd.free_commit) begin
            mem_wdata = cur_word & ~(32'd1 << r_bit);
        end
    end

    // map memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_map[r_ptr] <= mem_wdata;
        end
        r_rdata <= r_map[r_ptr];
    end

    // word valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_valid <= '0;
            r_rvalid     <= 1'b0;
        end else begin
            r_rvalid <= r_word_valid[r_ptr];
            if (i_cmd.restart) begin
                r_word_valid <= '0;
            end else if (mem_we) begin
                r_word_valid[r_ptr] <= 1'b1;
            end
        end
    end

    // item capture, pointers and range arithmetic
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_in_item;
        end
        if (i_cmd.scan_init) begin
            r_ptr <= '0;
        end else if (i_cmd.free_load) begin
            r_ptr <= free_idx[IDX_W-1:BIT_W];
            r_bit <= free_idx[BIT_W-1:0];
        end else if (i_cmd.walk_init) begin
            r_ptr <= r_first[IDX_W-1:BIT_W];
        end else if (i_cmd.ptr_inc) begin
            r_ptr <= r_ptr + WORD_W'(1);
        end
        if (i_cmd.range_sum) begin
            r_sum_len  <= {1'b0, r_item.address} + {1'b0, r_item.length};
            r_sum_pm   <= {1'b0, r_item.address} + {1'b0, PAGE_MASK};
            r_len_zero <= (r_item.length == 64'd0);
        end
        if (i_cmd.range_chk) begin
            r_range_ok <= !r_sum_len[64] && !r_sum_pm[64] && !r_len_zero
                          && (lo_pg < hi_pg) && (lo_pg < NP_LPW);
            r_first    <= lo_pg[IDX_W-1:0];
            r_lastm1   <= (hi_pg > NP_LPW) ? IDX_W'(NUM_PAGES - 1) : hi_m1[IDX_W-1:0];
        end
        if (i_cmd.capture) begin
            r_ok   <= 1'b0;
            r_page <= '0;
        end else if (i_cmd.alloc_commit) begin
            r_ok   <= 1'b1;
            r_page <= alloc_addr[ADDR_W-1:0];
        end
    end

    // counters and ready flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready     <= 1'b0;
            r_total     <= '0;
            r_used      <= '0;
            r_alloc_cnt <= '0;
            r_free_cnt  <= '0;
            r_fail_cnt  <= '0;
        end else if (i_cmd.restart) begin
            r_ready     <= 1'b0;
            r_total     <= '0;
            r_used      <= '0;
            r_alloc_cnt <= '0;
            r_free_cnt  <= '0;
            r_fail_cnt  <= '0;
        end else begin
            if (i_cmd.set_ready) begin
                r_ready <= 1'b1;
            end
            if (i_cmd.count_fail) begin
                r_fail_cnt <= r_fail_cnt + CTR_W'(1);
            end
            if (i_cmd.alloc_commit) begin
                r_used      <= r_used + CNT_W'(1);
                r_alloc_cnt <= r_alloc_cnt + CTR_W'(1);
            end
            if (i_cmd.free_commit) begin
                if (r_used != '0) begin
                    r_used <= r_used - CNT_W'(1);
                end
                r_free_cnt <= r_free_cnt + CTR_W'(1);
            end
            if (i_cmd.walk_commit) begin
                if (is_release) begin
                    r_total <= r_total + CNT_W'(pop);
                end else begin
                    r_used <= r_used + CNT_W'(pop);
                end
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out.page_address <= r_page;
            r_out.success      <= r_ok;
            r_out.total_pages  <= r_total;
            r_out.used_pages   <= r_used;
            r_out.free_pages   <= (r_total > r_used) ? (r_total - r_used) : '0;
            r_out.alloc_count  <= r_alloc_cnt;
            r_out.free_count   <= r_free_cnt;
            r_out.failed_count <= r_fail_cnt;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // status to the controller
    always_comb begin
        o_sts.op            = r_item.operation;
        o_sts.ready         = r_ready;
        o_sts.free_ok       = r_ready && ((r_item.address & PAGE_MASK) == 64'd0)
                              && (r_item.address < MAP_BYTES);
        o_sts.word_has_free = (inv_word != '0);
        o_sts.idx_in_map    = ({1'b0, r_ptr, first_bit} < NP_IDX);
        o_sts.scan_end      = (r_ptr == LAST_WORD);
        o_sts.bit_set       = cur_word[r_bit];
        o_sts.range_ok      = r_range_ok;
        o_sts.walk_end      = (r_ptr == r_lastm1[IDX_W-1:BIT_W]);
        o_sts.out_free      = !r_out_valid || !i_out_stall;
    end

endmodule

[design/page_bitmap_allocator.sv]
// ----------------------------------------------------------------------------
// page_bitmap_allocator
// First-fit page frame allocator over a one-bit-per-page used map.
// ----------------------------------------------------------------------------
// Input channel i_in_valid / o_in_stall carries one request item (operation,
// address, length); output channel o_out_valid / i_out_stall returns exactly
// one result item per request, in order. One request is worked on at a time.
// Start, restart, bad free, unknown codes and alloc when not ready go
// straight to the result; free reads one map word and, if the page is used,
// writes it back; alloc scans map words from word zero up to the first word
// with a free page (the map has 128 words); release and reserve check the
// page range, then walk each map word it touches. Each map word step is a
// registered read followed by a check or a write back of that word. With no
// receiver stall the next request is accepted on the edge at which the
// result of the previous one can first be taken. A finished result sits in
// the output register; the next request is taken while it waits, and its
// own result is held back until the receiver stops stalling. Reset (and the
// restart operation) marks every page used at once through per-word valid
// bits, zeroes all counters and clears ready; no clearing pass is needed and
// a request can be accepted as soon as reset is released.
// ----------------------------------------------------------------------------
module page_bitmap_allocator (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  pba_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output pba_pkg::t_out_item o_out_item
);
    import pba_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // sequencer
    pba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    // map, counters and output register
    pba_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cmd       (cmd),
        .i_out_stall (i_out_stall),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule
